// ===== src/rog_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the radius of gyration core.
// No dependencies; imported by rog_ctrl, rog_datapath and the top level.
package rog_pkg;

  localparam int MAX_PRIMARIES_DEF = 256;

  localparam int POS_W   = 16;
  localparam int RAD_W   = 10;
  localparam int OUT_W   = 16;
  localparam int STAT_W  = 2;
  localparam int WSUM_W  = 64;
  localparam int MSUM_W  = 40;
  localparam int MASS_W  = 3 * RAD_W;
  localparam int SQ_W    = 2 * POS_W - 1;
  localparam int DIST_W  = 2 * POS_W;
  localparam int TERM_W  = MASS_W + DIST_W - 8;
  localparam int QUO_W   = 2 * OUT_W;
  localparam int DIV_STEPS  = WSUM_W + 8;
  localparam int ROOT_STEPS = OUT_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_MASS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_MANY  = 2'd2;

  typedef struct packed {
    logic              in_take;   // a beat enters the MAC pipeline
    logic              in_acc;    // that beat is accumulated
    logic              div_load;
    logic              div_step;
    logic              root_load;
    logic              root_step;
    logic              res_load;
    logic [STAT_W-1:0] res_code;
    logic              acc_clear;
  } rog_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic mass_zero;
  } rog_stat_t;

endpackage

// ===== src/radius_of_gyration_core.sv =====
`timescale 1ns / 1ps
// Mass-weighted radius of gyration core: top level.
// Uses rog_pkg, rog_ctrl and rog_datapath.
//
// Usage:
//   Input beats (x_pos, y_pos, z_pos, radius, last_item) are taken at a
//   rising edge with start high and busy low. One primary per beat; mass is
//   radius cubed, weighted by the squared distance from the origin.
//   Beats without last_item are taken back to back, one per cycle, through
//   a four-stage multiply-accumulate pipeline; they produce no result.
//   A beat with last_item raises busy. The pipeline drains, then a
//   restoring divider runs, the RINIT state loads the square root, the
//   square root runs, and a last ROOT step loads the result; done then
//   rises. Error cases (too many primaries, zero total mass) load the
//   result as soon as the pipeline has drained and raise done, with
//   gyration_radius zero.
//   The result (gyration_radius, status) is valid for one cycle with done
//   high; the receiver cannot stall, so it must take it then. The
//   accumulators are cleared as the result leaves and the count as the last
//   beat is taken; busy drops the cycle after done.
//   Synchronous reset clears the accumulators, count and controller.
module radius_of_gyration_core #(
  parameter int MAX_PRIMARIES = rog_pkg::MAX_PRIMARIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rog_pkg::POS_W-1:0]   x_pos,
  input  logic [rog_pkg::POS_W-1:0]   y_pos,
  input  logic [rog_pkg::POS_W-1:0]   z_pos,
  input  logic [rog_pkg::RAD_W-1:0]   radius,
  input  logic                        last_item,
  output logic                        done,
  output logic [rog_pkg::OUT_W-1:0]   gyration_radius,
  output logic [rog_pkg::STAT_W-1:0]  status
);
  import rog_pkg::*;

  rog_cmd_t  cmd;
  rog_stat_t stat;

  rog_ctrl #(
    .MAX_PRIMARIES(MAX_PRIMARIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .stat      (stat)
  );

  rog_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .x_pos           (x_pos),
    .y_pos           (y_pos),
    .z_pos           (z_pos),
    .radius          (radius),
    .gyration_radius (gyration_radius),
    .status          (status)
  );

endmodule

// ===== src/rog_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: squared-distance and mass MAC pipeline, accumulators,
// restoring divider and digit-by-digit square root. Uses rog_pkg.
module rog_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rog_pkg::rog_cmd_t            cmd,
  output rog_pkg::rog_stat_t           stat,
  input  logic [rog_pkg::POS_W-1:0]    x_pos,
  input  logic [rog_pkg::POS_W-1:0]    y_pos,
  input  logic [rog_pkg::POS_W-1:0]    z_pos,
  input  logic [rog_pkg::RAD_W-1:0]    radius,
  output logic [rog_pkg::OUT_W-1:0]    gyration_radius,
  output logic [rog_pkg::STAT_W-1:0]   status
);
  import rog_pkg::*;

  logic [POS_W-1:0] ax, ay, az;

  // stage 1: squares
  logic              v1;
  logic [SQ_W-1:0]   sx, sy, sz;
  logic [2*RAD_W-1:0] r2;
  logic [RAD_W-1:0]  r1;
  // stage 2: distance squared and mass
  logic              v2;
  logic [DIST_W-1:0] d2;
  logic [MASS_W-1:0] mass2;
  // stage 3: weighted term
  logic              v3;
  logic [MASS_W+DIST_W-1:0] prod;
  logic [MASS_W-1:0] mass3;

  logic [WSUM_W-1:0] wsum;
  logic [MSUM_W-1:0] msum;

  // divider
  logic [MSUM_W-1:0]   drem;
  logic [DIV_STEPS-1:0] dsr;
  logic [QUO_W-1:0]    quo;
  logic                sat;
  logic [MSUM_W:0]     dtrial;
  logic                dbit;

  // square root
  logic [QUO_W-1:0]    rval;
  logic [OUT_W:0]      rrem;
  logic [OUT_W-1:0]    root;
  logic [OUT_W+2:0]    rtrial;
  logic [OUT_W+2:0]    rsub;
  logic                rbit;

  assign ax = x_pos[POS_W-1] ? (~x_pos + 1'b1) : x_pos;
  assign ay = y_pos[POS_W-1] ? (~y_pos + 1'b1) : y_pos;
  assign az = z_pos[POS_W-1] ? (~z_pos + 1'b1) : z_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.in_take && cmd.in_acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sx    <= SQ_W'(ax) * SQ_W'(ax);
    sy    <= SQ_W'(ay) * SQ_W'(ay);
    sz    <= SQ_W'(az) * SQ_W'(az);
    r2    <= radius * radius;
    r1    <= radius;
    d2    <= DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);
    mass2 <= MASS_W'(r2) * MASS_W'(r1);
    prod  <= mass2 * d2;
    mass3 <= mass2;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) begin
      wsum <= '0;
      msum <= '0;
    end else if (v3) begin
      wsum <= wsum + WSUM_W'(prod[MASS_W+DIST_W-1:8]);
      msum <= msum + MSUM_W'(mass3);
    end
  end

  assign stat.pipe_empty = !(v1 || v2 || v3);
  assign stat.mass_zero  = (msum == '0);

  // one quotient bit per step; bits above the kept window only saturate
  assign dtrial = {drem, dsr[DIV_STEPS-1]};
  assign dbit   = (dtrial >= {1'b0, msum});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      drem <= '0;
      dsr  <= {wsum, 8'b0};
      quo  <= '0;
      sat  <= 1'b0;
    end else if (cmd.div_step) begin
      drem <= dbit ? MSUM_W'(dtrial - {1'b0, msum}) : MSUM_W'(dtrial);
      dsr  <= {dsr[DIV_STEPS-2:0], 1'b0};
      quo  <= {quo[QUO_W-2:0], dbit};
      sat  <= sat | quo[QUO_W-1];
    end
  end

  assign rtrial = {1'b0, root, 2'b01};
  assign rsub   = {rrem, rval[QUO_W-1:QUO_W-2]};
  assign rbit   = (rsub >= rtrial);

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rval <= quo;
      rrem <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rval <= {rval[QUO_W-3:0], 2'b00};
      rrem <= rbit ? (OUT_W+1)'(rsub - rtrial) : (OUT_W+1)'(rsub);
      root <= {root[OUT_W-2:0], rbit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_code;
      if (cmd.res_code != STAT_OK) begin
        gyration_radius <= '0;
      end else begin
        gyration_radius <= sat ? {OUT_W{1'b1}} : root;
      end
    end
  end

endmodule

// ===== src/rog_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: handshake, primary count, and the divide/root sequencer.
// Uses rog_pkg; drives rog_datapath through rog_cmd_t.
module rog_ctrl #(
  parameter int MAX_PRIMARIES = rog_pkg::MAX_PRIMARIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               last_item,
  output logic               busy,
  output logic               done,
  output rog_pkg::rog_cmd_t  cmd,
  input  rog_pkg::rog_stat_t stat
);
  import rog_pkg::*;

  localparam int CNT_W = $clog2(MAX_PRIMARIES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PRIMARIES);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DRAIN = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_RINIT = 6'b001000,
    ST_ROOT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] item_cnt, cnt_inc;
  logic             over;
  logic             take;
  logic [STEP_W-1:0] step, step_next;
  logic             fin;   // final square-root step of ROOT; the result loads after it

  assign take    = start && !busy;
  assign cnt_inc = (item_cnt <= CNT_MAX) ? item_cnt + 1'b1 : item_cnt;
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_cnt <= '0;
      over     <= 1'b0;
    end else if (take) begin
      item_cnt <= last_item ? '0 : cnt_inc;
      if (last_item) begin
        over <= (cnt_inc > CNT_MAX);
      end
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    fin           = 1'b0;
    cmd           = '0;
    cmd.in_take   = take;
    cmd.in_acc    = (cnt_inc <= CNT_MAX);
    cmd.res_code  = STAT_OK;
    unique case (state)
      ST_IDLE: begin
        if (take && last_item) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          if (over) begin
            cmd.res_load = 1'b1;
            cmd.res_code = STAT_TOO_MANY;
            state_next   = ST_DONE;
          end else if (stat.mass_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_code = STAT_ZERO_MASS;
            state_next   = ST_DONE;
          end else begin
            cmd.div_load = 1'b1;
            step_next    = STEP_W'(DIV_STEPS - 1);
            state_next   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step - 1'b1;
        if (step == '0) begin
          state_next = ST_RINIT;
        end
      end
      ST_RINIT: begin
        cmd.root_load = 1'b1;
        step_next     = STEP_W'(ROOT_STEPS - 1);
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        if (step == '0) begin
          fin = 1'b1;
        end
        cmd.root_step = !fin && (step != '1);
        step_next     = step - 1'b1;
        // step wraps to all ones for the one cycle that loads the result
        if (step == '1) begin
          cmd.res_load = 1'b1;
          state_next   = ST_DONE;
        end
        if (fin) begin
          cmd.root_step = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.acc_clear = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign done = (state == ST_DONE);

  a_last_sets_busy: assert property (@(posedge clk) disable iff (rst)
    take && last_item |=> busy)
    else $error("last beat did not start the result sequence");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_div_to_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && (step == '0) |=> (state == ST_RINIT))
    else $error("divider did not hand over to square root");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_cnt <= CNT_MAX + 1'b1)
    else $error("primary count beyond saturation");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> stat.pipe_empty)
    else $error("result issued with beats still in the pipeline");

endmodule
